// File: rtl/core/calendar_date_counter_core_macros.svh
// Assertion macros of the calendar date counter checker
`ifndef CALENDAR_DATE_COUNTER_CORE_MACROS_SVH
`define CALENDAR_DATE_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date counter check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define CDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date counter check failed");

`endif

// File: rtl/core/cdc_pkg.sv
// Shared types and constants of the calendar date counter
package cdc_pkg;

    localparam int MAX_ADVANCE = 65535;
    localparam int CNT_W       = $clog2(MAX_ADVANCE + 1);

    localparam logic KIND_SET     = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [11:0] YEAR_MIN     = 12'd1900;
    localparam logic [11:0] YEAR_MAX_SET = 12'd2100;
    localparam logic [11:0] YEAR_DEFAULT = 12'd2021;
    localparam logic [11:0] YEAR_CEILING = 12'd4095;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } cdc_state_t;

    typedef struct packed {
        logic load_date;
        logic load_count;
        logic step;
    } cdc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_last;
    } cdc_stat_t;

endpackage

// File: rtl/core/calendar_date_counter_core.sv
// Calendar date counter top level: controller and datapath
// A set item (kind 0) or an advance by zero days returns its date in the cycle
// after start; an advance by n days returns it once all n days are stepped, as
// the day step unit moves the date by one day per cycle. busy is high while
// days are being stepped; start is taken whenever busy is low, including in
// the cycle that shows a result. Each result is shown for a single cycle,
// marked by done, and cannot be held off: capture it in that cycle. The
// outputs keep showing the current date between results.
module calendar_date_counter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        kind,
    input  logic [5:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [11:0] year_in,
    input  logic [15:0] count,
    output logic        busy,
    output logic        done,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [11:0] year_out,
    output logic        leap_year
);
    import cdc_pkg::*;

    cdc_cmd_t  cmd;
    cdc_stat_t stat;

    cdc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cdc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .day_in    (day_in),
        .month_in  (month_in),
        .year_in   (year_in),
        .count     (count),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .leap_year (leap_year)
    );

endmodule

// File: rtl/core/cdc_ctrl.sv
// Controller state machine of the calendar date counter
module cdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              kind,
    input  cdc_pkg::cdc_stat_t stat,
    output cdc_pkg::cdc_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import cdc_pkg::*;

    cdc_state_t state_reg, state_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_SET)
                    begin
                        cmd.load_date = 1'b1;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.load_count = 1'b1;
                        // zero days: answer at once with the date held
                        if (stat.count_zero)
                            done_next = 1'b1;
                        else
                            state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                busy     = 1'b1;
                cmd.step = 1'b1;
                if (stat.count_last)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// File: rtl/core/cdc_dp.sv
// Datapath of the calendar date counter: date registers, day step and day count
module cdc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  cdc_pkg::cdc_cmd_t  cmd,
    output cdc_pkg::cdc_stat_t stat,
    input  logic [5:0]        day_in,
    input  logic [3:0]        month_in,
    input  logic [11:0]       year_in,
    input  logic [15:0]       count,
    output logic [4:0]        day_out,
    output logic [3:0]        month_out,
    output logic [11:0]       year_out,
    output logic              leap_year
);
    import cdc_pkg::*;

    // year is also kept as century and year within century, so that the leap rule
    // needs only the low bits of each and a zero test of the year within century
    localparam logic [5:0]  CENT_DEFAULT = 6'(YEAR_DEFAULT / 100);
    localparam logic [6:0]  LO_DEFAULT   = 7'(YEAR_DEFAULT % 100);
    localparam logic [11:0] Y1900        = 12'd1900;
    localparam logic [11:0] Y2000        = 12'd2000;
    localparam logic [11:0] Y2100        = 12'd2100;
    localparam logic [6:0]  LO_LAST      = 7'd99;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    function automatic logic leap_of(input logic [5:0] cent, input logic [6:0] lo);
        if (lo == 7'd0)
            return cent[1:0] == 2'd0;
        else
            return lo[1:0] == 2'd0;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[month];
        if (month == 4'd2 && leap)
            len = 5'd29;
        return len;
    endfunction

    logic [4:0]       day_reg, day_next;
    logic [3:0]       month_reg, month_next;
    logic [11:0]      year_reg, year_next;
    logic [5:0]       cent_reg, cent_next;
    logic [6:0]       lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [3:0]       month_sel;
    logic [11:0]      year_sel;
    logic [5:0]       cent_sel;
    logic [6:0]       lo_sel;
    logic [4:0]       dim_sel;
    logic [4:0]       day_sel;
    logic [4:0]       dim_cur;
    logic             leap_cur;
    logic [CNT_W-1:0] cnt_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= YEAR_DEFAULT;
            cent_reg  <= CENT_DEFAULT;
            lo_reg    <= LO_DEFAULT;
            cnt_reg   <= '0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            cent_reg  <= cent_next;
            lo_reg    <= lo_next;
            cnt_reg   <= cnt_next;
        end
    end

    // checked date for a set item
    always_comb
    begin
        month_sel = (month_in >= 4'd1 && month_in <= 4'd12) ? month_in : 4'd1;
        year_sel  = (year_in >= YEAR_MIN && year_in <= YEAR_MAX_SET) ? year_in
                                                                      : YEAR_DEFAULT;
        priority if (year_sel >= Y2100)
        begin
            cent_sel = 6'd21;
            lo_sel   = 7'(year_sel - Y2100);
        end
        else if (year_sel >= Y2000)
        begin
            cent_sel = 6'd20;
            lo_sel   = 7'(year_sel - Y2000);
        end
        else
        begin
            cent_sel = 6'd19;
            lo_sel   = 7'(year_sel - Y1900);
        end
        dim_sel = days_in(month_sel, leap_of(cent_sel, lo_sel));
        day_sel = (day_in != 6'd0 && day_in <= {1'b0, dim_sel}) ? day_in[4:0] : 5'd1;
    end

    assign leap_cur = leap_of(cent_reg, lo_reg);
    assign dim_cur  = days_in(month_reg, leap_cur);
    assign cnt_load = (32'(count) > MAX_ADVANCE) ? CNT_W'(MAX_ADVANCE) : CNT_W'(count);

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cent_next  = cent_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        if (cmd.load_date)
        begin
            day_next   = day_sel;
            month_next = month_sel;
            year_next  = year_sel;
            cent_next  = cent_sel;
            lo_next    = lo_sel;
        end
        if (cmd.load_count)
            cnt_next = cnt_load;
        if (cmd.step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            priority if (day_reg < dim_cur)
            begin
                day_next = day_reg + 5'd1;
            end
            else if (month_reg < 4'd12)
            begin
                month_next = month_reg + 4'd1;
                day_next   = 5'd1;
            end
            else if (year_reg < YEAR_CEILING)
            begin
                year_next  = year_reg + 12'd1;
                month_next = 4'd1;
                day_next   = 5'd1;
                if (lo_reg == LO_LAST)
                begin
                    lo_next   = 7'd0;
                    cent_next = cent_reg + 6'd1;
                end
                else
                begin
                    lo_next = lo_reg + 7'd1;
                end
            end
            else
            begin
                // hold 31 December of the ceiling year
                day_next = day_reg;
            end
        end
    end

    assign stat.count_zero = (cnt_load == '0);
    assign stat.count_last = (cnt_reg == CNT_W'(1));

    assign day_out   = day_reg;
    assign month_out = month_reg;
    assign year_out  = year_reg;
    assign leap_year = leap_cur;

endmodule

// File: rtl/core/cdc_checker.sv
// Port-level checker of the calendar date counter, bound to the top level
`include "calendar_date_counter_core_macros.svh"

module cdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        kind,
    input logic [5:0]  day_in,
    input logic [3:0]  month_in,
    input logic [11:0] year_in,
    input logic [15:0] count,
    input logic        busy,
    input logic        done,
    input logic [4:0]  day_out,
    input logic [3:0]  month_out,
    input logic [11:0] year_out,
    input logic        leap_year
);
    import cdc_pkg::*;

    logic        set_take;
    logic        adv_zero;
    logic        adv_some;
    logic [20:0] date_now;
    logic        date_ok;

    assign set_take = start && !busy && kind == KIND_SET;
    assign adv_zero = start && !busy && kind == KIND_ADVANCE && count == 16'd0;
    assign adv_some = start && !busy && kind == KIND_ADVANCE && count != 16'd0;
    assign date_now = {day_out, month_out, year_out};
    assign date_ok  = day_out != 5'd0 && month_out != 4'd0 && month_out <= 4'd12
                      && year_out >= YEAR_MIN;

    // a result is only shown once stepping is over
    `CDC_ASSERT_NOW(a_done_not_busy, done, !busy)
    // a set item answers in the next cycle
    `CDC_ASSERT_NEXT(a_set_one_cycle, set_take, done && !busy)
    // an advance by zero days answers in the next cycle with the date unchanged
    `CDC_ASSERT_NEXT(a_zero_advance, adv_zero, done && $stable(date_now))
    // an advance by some days starts stepping
    `CDC_ASSERT_NEXT(a_advance_busy, adv_some, busy && !done)
    // every result carries a real date
    `CDC_ASSERT_NOW(a_date_range, done, date_ok)

endmodule

bind calendar_date_counter_core cdc_checker u_cdc_checker (.*);
